// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the synthesizer core.
// ----------------------------------------------------------------------------
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/wns_pkg.sv =====
// ----------------------------------------------------------------------------
// wns_pkg
// Types, constants and helper functions of the wavetable and noise synthesizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wns_pkg;

    localparam int WNS_VOICES    = 8;
    localparam int WNS_RAM_BYTES = 1024;

    localparam int SLOTS      = 8;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int ADDR_W     = 10;
    localparam int DATA_W     = 8;
    localparam int SAMPLE_W   = 15;
    localparam int VOL_W      = 4;
    localparam int WAVE_W     = 4;
    localparam int FREQ_W     = 20;
    localparam int SCALE_W    = 20;
    localparam int PROD_W     = FREQ_W + SCALE_W;
    localparam int FRAC_W     = 16;
    localparam int PHASE_W    = 32;
    localparam int NPHASE_W   = 12;
    localparam int NSUM_W     = 18;
    localparam int CNT_W      = NSUM_W - NPHASE_W;
    localparam int LFSR_W     = 18;
    localparam int NOISE_SHIFT = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [ADDR_W-1:0]   REG_BASE  = 10'h100;
    localparam logic [ADDR_W-1:0]   REG_END   = 10'h140;
    localparam logic [LFSR_W-1:0]   LFSR_TAP  = 18'h28000;
    localparam logic [LFSR_W-1:0]   LFSR_SEED = 18'h00001;
    localparam logic [SAMPLE_W-1:0] NOISE_AMP = 15'd7;
    localparam logic [SAMPLE_W-1:0] WAVE_BIAS = 15'd128;
    localparam logic [SCALE_W-1:0]  SCALE_RESET = 20'h10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SCALE   = 2'd2;

    // Byte offsets within one voice's eight-byte register group.
    localparam logic [2:0] REG_OFF_VOLUME  = 3'd0;
    localparam logic [2:0] REG_OFF_WAVE    = 3'd1;
    localparam logic [2:0] REG_OFF_FREQ_MD = 3'd2;
    localparam logic [2:0] REG_OFF_FREQ_LO = 3'd3;
    localparam logic [2:0] REG_OFF_NOISE   = 3'd4;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_VOICE,
        ST_WPH,
        ST_WACC,
        ST_NPH,
        ST_NSTEP,
        ST_DONE
    } wns_state_t;

    // One shift of the noise generator.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] t;
        t = s[0] ? (s ^ LFSR_TAP) : s;
        return t >> 1;
    endfunction

    // The noise output flips when the two low bits of the state differ.
    function automatic logic lfsr_flip(input logic [LFSR_W-1:0] s);
        return s[0] ^ s[1];
    endfunction

endpackage

// ===== rtl/core/wns_if.sv =====
// ----------------------------------------------------------------------------
// wns_req_if / wns_rsp_if
// Valid/ready channels carrying bus requests in and results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wns_req_if import wns_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          opcode;
    logic [ADDR_W-1:0]   address;
    logic [DATA_W-1:0]   write_data;

    modport source (output valid, output opcode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input address, input write_data,
                    output ready);
endinterface

interface wns_rsp_if import wns_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [DATA_W-1:0]          read_data;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output read_data, output sample, input ready);
    modport sink   (input valid, input read_data, input sample, output ready);
endinterface

// ===== rtl/core/wns_ram.sv =====
// ----------------------------------------------------------------------------
// wns_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/wns_mul.sv =====
// ----------------------------------------------------------------------------
// wns_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wns_mul import wns_pkg::*; (
    input  logic               clk,
    input  logic [FREQ_W-1:0]  a,
    input  logic [SCALE_W-1:0] b,
    output logic [PROD_W-1:0]  prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/wavetable_noise_synth_8voice.sv =====
// ----------------------------------------------------------------------------
// wavetable_noise_synth_8voice
// Eight-voice wavetable and noise sound generator behind a byte-wide RAM.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (valid/ready): a bus read, a bus write or
// a sample tick. Every request gives exactly one result on the rsp channel:
// the RAM byte for a read, the mixed signed sample for a tick, zeros otherwise.
// Configuration (sound enable, voice count, frequency scale) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while no request is in
// flight, which the block itself does not enforce. Up to the done state that
// loads the result, a read passes a RAM read state and a write a state that reads
// and compares the old byte before the write; an unused opcode, an out-of-range
// address or a tick with sound disabled goes directly. A tick visits each
// active voice in the voice state, a silent one only there, a wave one also in
// the wave-phase and accumulate states, a noise one in the noise-phase state
// and a noise-step state repeated until its generator has made all its shifts.
// The shared multiplier, the single RAM port and the one-shift-per-cycle noise
// generator make this sequential; one request is in work at a time. After reset
// the wave RAM is swept to zero, one byte per cycle; req.ready stays low during
// that sweep. The result sits in an output register, so a new request is taken
// while the previous result waits; when the receiver stalls, the next result
// waits in the core until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wavetable_noise_synth_8voice import wns_pkg::*; #(
    parameter int VOICES    = WNS_VOICES,
    parameter int RAM_BYTES = WNS_RAM_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    wns_req_if.sink               req,
    wns_rsp_if.source             rsp
);

    localparam int AW = $clog2(RAM_BYTES);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    // Configuration registers.
    logic                sound_enable_reg;
    logic [COUNT_W-1:0]  voice_count_reg;
    logic [SCALE_W-1:0]  freq_scale_reg;

    // Per-slot voice registers, decoded from writes into the register window.
    logic [VOL_W-1:0]    vol_reg      [SLOTS];
    logic [WAVE_W-1:0]   wave_reg     [SLOTS];
    logic [FREQ_W-1:0]   freq_reg     [SLOTS];
    logic                noise_en_reg [SLOTS];

    // Per-voice oscillator state.
    logic [PHASE_W-1:0]  wphase_reg [VOICES];
    logic [NPHASE_W-1:0] nphase_reg [VOICES];
    logic [LFSR_W-1:0]   lfsr_reg   [VOICES];
    logic                nlevel_reg [VOICES];

    // Sequencer state.
    wns_state_t          state_reg, state_next;
    logic [SLOT_W-1:0]   v_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [AW-1:0]       clr_reg;
    logic                out_valid_reg;

    // Request and result payload.
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [SAMPLE_W-1:0] acc_reg;
    logic [DATA_W-1:0]   rd_res_reg;
    logic [DATA_W-1:0]   out_read_data_reg;
    logic [SAMPLE_W-1:0] out_sample_reg;

    // RAM and multiplier hookup.
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [DATA_W-1:0]   ram_rdata;
    logic [FREQ_W-1:0]   mul_a;
    logic [SCALE_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_prod;

    // Decoded helpers.
    logic                req_ready;
    logic                req_in_range;
    logic [COUNT_W-1:0]  n_active;
    logic                last_voice;
    logic                voice_done;
    logic [VW-1:0]       vi;
    logic [VOL_W-1:0]    cur_vol;
    logic [WAVE_W-1:0]   cur_wave;
    logic [FREQ_W-1:0]   cur_freq;
    logic                cur_noise;
    logic [PHASE_W-1:0]  cur_wphase;
    logic [NPHASE_W-1:0] cur_nphase;
    logic [LFSR_W-1:0]   cur_lfsr;
    logic                cur_level;
    logic [NSUM_W-1:0]   nsum;
    logic [SAMPLE_W-1:0] noise_amp;
    logic                wr_changed;
    logic                wr_in_regs;
    logic [SLOT_W-1:0]   wr_slot;
    logic [COUNT_W-1:0]  wr_next4;
    logic [SLOT_W-1:0]   wr_noise_tgt;

    wns_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    wns_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // A voice count of zero behaves as one, and anything above the number of
    // built voices is clipped to it.
    always_comb
    begin
        if (voice_count_reg == '0)
        begin
            n_active = COUNT_W'(1);
        end
        else if (voice_count_reg > COUNT_W'(VOICES))
        begin
            n_active = COUNT_W'(VOICES);
        end
        else
        begin
            n_active = voice_count_reg;
        end
    end

    assign vi         = v_reg[VW-1:0];
    assign cur_vol    = vol_reg[v_reg];
    assign cur_wave   = wave_reg[v_reg];
    assign cur_freq   = freq_reg[v_reg];
    assign cur_noise  = noise_en_reg[v_reg];
    assign cur_wphase = wphase_reg[vi];
    assign cur_nphase = nphase_reg[vi];
    assign cur_lfsr   = lfsr_reg[vi];
    assign cur_level  = nlevel_reg[vi];
    assign last_voice = (COUNT_W'(v_reg) + COUNT_W'(1)) == n_active;

    assign req_in_range = int'(req.address) < RAM_BYTES;

    // Noise phase plus the scaled increment; the bits above the 12-bit phase
    // count how many times the noise generator must shift.
    assign nsum = NSUM_W'(cur_nphase) + NSUM_W'(mul_prod[FRAC_W +: NSUM_W-1]);
    assign noise_amp = SAMPLE_W'(cur_vol) * NOISE_AMP;

    // Bus write decode. Only a write that changes the stored byte has an
    // effect on the voice registers.
    assign wr_changed   = ram_rdata != data_reg;
    assign wr_in_regs   = (addr_reg >= REG_BASE) && (addr_reg < REG_END);
    assign wr_slot      = addr_reg[SLOT_W+2:3];
    assign wr_next4     = COUNT_W'(wr_slot) + COUNT_W'(1);
    assign wr_noise_tgt = (wr_next4 == n_active || wr_next4 >= COUNT_W'(SLOTS))
                          ? '0 : wr_next4[SLOT_W-1:0];

    // Sequencer: next state, RAM port and multiplier operand selection.
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_addr   = addr_reg[AW-1:0];
        ram_wdata  = data_reg;
        mul_a      = cur_freq;
        mul_b      = freq_scale_reg;
        req_ready  = 1'b0;
        voice_done = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                if (clr_reg == AW'(RAM_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                ram_addr  = req.address[AW-1:0];
                if (req.valid)
                begin
                    unique case (opcode_t'(req.opcode))
                        OP_READ:  state_next = req_in_range ? ST_RD : ST_DONE;
                        OP_WRITE: state_next = req_in_range ? ST_WR : ST_DONE;
                        OP_TICK:  state_next = sound_enable_reg ? ST_VOICE : ST_DONE;
                        OP_NONE:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_RD:
            begin
                state_next = ST_DONE;
            end
            ST_WR:
            begin
                ram_we     = wr_changed;
                state_next = ST_DONE;
            end
            ST_VOICE:
            begin
                if (cur_vol == '0)
                begin
                    voice_done = 1'b1;
                end
                else if (cur_noise)
                begin
                    mul_a      = FREQ_W'({cur_freq[7:0], NOISE_SHIFT'(0)});
                    state_next = ST_NPH;
                end
                else
                begin
                    ram_addr   = AW'({cur_wave, cur_wphase[FRAC_W +: 4]});
                    state_next = ST_WPH;
                end
            end
            ST_WPH:
            begin
                mul_a      = FREQ_W'(ram_rdata);
                mul_b      = SCALE_W'(cur_vol);
                state_next = ST_WACC;
            end
            ST_WACC:
            begin
                voice_done = 1'b1;
            end
            ST_NPH:
            begin
                state_next = ST_NSTEP;
            end
            ST_NSTEP:
            begin
                voice_done = cnt_reg == '0;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (voice_done)
        begin
            state_next = last_voice ? ST_DONE : ST_VOICE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg <= 1'b1;
            voice_count_reg  <= COUNT_W'(SLOTS);
            freq_scale_reg   <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOUND_ENABLE: sound_enable_reg <= cfg_data[0];
                CFG_VOICE_COUNT:  voice_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_FREQ_SCALE:   freq_scale_reg   <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Control counters, voice registers and oscillator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SLOTS; s++)
            begin
                vol_reg[s]      <= '0;
                wave_reg[s]     <= '0;
                freq_reg[s]     <= '0;
                noise_en_reg[s] <= 1'b0;
            end
            for (int v = 0; v < VOICES; v++)
            begin
                wphase_reg[v] <= '0;
                nphase_reg[v] <= '0;
                lfsr_reg[v]   <= LFSR_SEED;
                nlevel_reg[v] <= 1'b0;
            end
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end

            if (state_reg == ST_DONE && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_IDLE)
            begin
                v_reg <= '0;
            end
            else if (voice_done && !last_voice)
            begin
                v_reg <= v_reg + SLOT_W'(1);
            end

            if (state_reg == ST_WR && wr_changed && wr_in_regs)
            begin
                unique case (addr_reg[2:0])
                    REG_OFF_VOLUME:
                    begin
                        vol_reg[wr_slot] <= data_reg[VOL_W-1:0];
                    end
                    REG_OFF_WAVE:
                    begin
                        wave_reg[wr_slot]       <= data_reg[DATA_W-1:DATA_W-WAVE_W];
                        freq_reg[wr_slot][19:16] <= data_reg[3:0];
                    end
                    REG_OFF_FREQ_MD:
                    begin
                        freq_reg[wr_slot][15:8] <= data_reg;
                    end
                    REG_OFF_FREQ_LO:
                    begin
                        freq_reg[wr_slot][7:0] <= data_reg;
                    end
                    REG_OFF_NOISE:
                    begin
                        noise_en_reg[wr_noise_tgt] <= data_reg[DATA_W-1];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_WPH)
            begin
                wphase_reg[vi] <= cur_wphase + PHASE_W'(mul_prod[PROD_W-1:FRAC_W]);
            end

            if (state_reg == ST_NPH)
            begin
                nphase_reg[vi] <= nsum[NPHASE_W-1:0];
                cnt_reg        <= nsum[NSUM_W-1:NPHASE_W];
            end

            if (state_reg == ST_NSTEP && cnt_reg != '0)
            begin
                lfsr_reg[vi]   <= lfsr_next(cur_lfsr);
                nlevel_reg[vi] <= cur_level ^ lfsr_flip(cur_lfsr);
                cnt_reg        <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Request capture, accumulation and the result register.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            addr_reg   <= req.address;
            data_reg   <= req.write_data;
            acc_reg    <= '0;
            rd_res_reg <= '0;
        end

        if (state_reg == ST_RD)
        begin
            rd_res_reg <= ram_rdata;
        end

        // A noise voice contributes plus or minus seven times its volume.
        if (state_reg == ST_VOICE && cur_vol != '0 && cur_noise)
        begin
            acc_reg <= cur_level ? (acc_reg + noise_amp) : (acc_reg - noise_amp);
        end

        // A wave voice contributes (byte - 128) * volume, formed from the
        // unsigned product minus the bias times the volume.
        if (state_reg == ST_WACC)
        begin
            acc_reg <= acc_reg + SAMPLE_W'(mul_prod[DATA_W+VOL_W-1:0])
                       - (WAVE_BIAS * SAMPLE_W'(cur_vol));
        end

        if (state_reg == ST_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_read_data_reg <= rd_res_reg;
            out_sample_reg    <= acc_reg;
        end
    end

    assign req.ready     = req_ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_read_data_reg;
    assign rsp.sample    = $signed(out_sample_reg);

    `WNS_ASSERT_NOW(a_no_req_in_clear, state_reg == ST_CLEAR, !req.ready, "request taken during RAM clear")
    `WNS_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_reg != ST_IDLE, "sequencer stayed idle after a request")
    `WNS_ASSERT_NOW(a_voice_in_range, state_reg == ST_VOICE, COUNT_W'(v_reg) < n_active, "voice index beyond active count")
    `WNS_ASSERT_NOW(a_one_result_field, rsp.valid, rsp.read_data == '0 || rsp.sample == '0, "read data and sample both nonzero")

endmodule
